FILE: rtl/core/sorted_store_range_count_core_defines.svh
// assertion helpers shared by the core
`ifndef SORTED_STORE_RANGE_COUNT_CORE_DEFINES_SVH
`define SORTED_STORE_RANGE_COUNT_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define SSRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define SSRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ssrc_pkg.sv
package ssrc_pkg;

    localparam int VALUE_W       = 32;
    localparam int ACTION_W      = 2;
    localparam int COUNT_W       = 11;
    localparam int STORE_DEPTH_D = 1024;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [ACTION_W-1:0]       t_action;

    localparam t_action ACT_INSERT = 2'd0;
    localparam t_action ACT_QUERY  = 2'd1;
    localparam t_action ACT_CLEAR  = 2'd2;

endpackage

FILE: rtl/core/ssrc_if.sv
interface ssrc_req_if;
    logic              valid;
    logic              ready;
    ssrc_pkg::t_action action;
    ssrc_pkg::t_value  item_value;
    ssrc_pkg::t_value  upper_bound;

    modport source (output valid, output action, output item_value, output upper_bound,
                    input ready);
    modport sink   (input valid, input action, input item_value, input upper_bound,
                    output ready);
endinterface

interface ssrc_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ssrc_pkg::COUNT_W-1:0] match_count;
    logic                         status;

    modport source (output valid, output match_count, output status, input ready);
    modport sink   (input valid, input match_count, input status, output ready);
endinterface

FILE: rtl/core/sorted_store_range_count_core.sv
// Sorted store of signed 32-bit values with an inclusive range count, one word out
// for every word in. All work runs through one store with a separate write port and
// a registered read, and one signed comparator serves the search, so each binary-search
// probe passes through a read state (ST_PROBE) and a compare state (ST_CMP). A query
// runs two searches; an insert runs one search, then moves every stored value above
// the new one up a place through ST_SHIFT and ST_MOVE before writing it; a clear, an
// unused code, a full-store insert, an empty-store query or a query with low above
// high go straight to ST_DONE. The result sits in an output register, so the next
// word can be accepted while it waits to be taken. No clearing pass after reset.
`include "sorted_store_range_count_core_defines.svh"

module sorted_store_range_count_core #(
    parameter int STORE_DEPTH = ssrc_pkg::STORE_DEPTH_D
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssrc_req_if.sink   i_req,
    ssrc_rsp_if.source o_rsp
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PROBE = 6'b000010,
        ST_CMP   = 6'b000100,
        ST_SHIFT = 6'b001000,
        ST_MOVE  = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    t_state                       r_state, n_state;
    logic [CW-1:0]                r_count, n_count;
    logic [CW-1:0]                r_lo, n_lo;
    logic [CW-1:0]                r_hi, n_hi;
    logic [CW-1:0]                r_ub, n_ub;
    ssrc_pkg::t_value             r_key, n_key;
    ssrc_pkg::t_value             r_low, n_low;
    ssrc_pkg::t_action            r_action, n_action;
    logic                         r_strict, n_strict;
    logic                         r_phase, n_phase;
    logic [AW-1:0]                r_pos, n_pos;
    logic [AW-1:0]                r_idx, n_idx;
    logic [CW-1:0]                r_res_count, n_res_count;
    logic                         r_res_status, n_res_status;
    logic                         r_out_valid, n_out_valid;
    logic [ssrc_pkg::COUNT_W-1:0] r_out_count, n_out_count;
    logic                         r_out_status, n_out_status;

    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    ssrc_pkg::t_value mem_wr_data;
    logic             mem_rd_en;
    logic [AW-1:0]    mem_rd_addr;
    ssrc_pkg::t_value mem_rd_data;

    logic [CW-1:0] mid;
    logic          go_right;
    logic          out_free;
    logic [31:0]   res_ext;

    ssrc_store #(
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign mid      = r_lo + ((r_hi - r_lo) >> 1);
    // strict search finds the first entry above the key, otherwise the first not below
    assign go_right = r_strict ? (mem_rd_data <= r_key) : (mem_rd_data < r_key);
    assign out_free = !r_out_valid || o_rsp.ready;
    assign res_ext  = 32'(r_res_count);

    assign i_req.ready       = (r_state == ST_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.match_count = r_out_count;
    assign o_rsp.status      = r_out_status;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_ub         = r_ub;
        n_key        = r_key;
        n_low        = r_low;
        n_action     = r_action;
        n_strict     = r_strict;
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_idx        = r_idx;
        n_res_count  = r_res_count;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = r_pos;
        mem_wr_data  = r_key;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = mid[AW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_action     = i_req.action;
                    n_low        = i_req.item_value;
                    n_lo         = '0;
                    n_hi         = r_count;
                    n_phase      = 1'b0;
                    n_res_status = 1'b0;
                    n_res_count  = r_count;
                    n_state      = ST_DONE;
                    case (i_req.action)
                        ssrc_pkg::ACT_INSERT: begin
                            if (r_count == CW'(STORE_DEPTH)) begin
                                n_res_status = 1'b1;
                            end else begin
                                n_key    = i_req.item_value;
                                n_strict = 1'b1;
                                n_state  = ST_PROBE;
                            end
                        end
                        ssrc_pkg::ACT_QUERY: begin
                            if (r_count == '0 || i_req.item_value > i_req.upper_bound) begin
                                n_res_count = '0;
                            end else begin
                                n_key    = i_req.upper_bound;
                                n_strict = 1'b1;
                                n_state  = ST_PROBE;
                            end
                        end
                        ssrc_pkg::ACT_CLEAR: begin
                            n_count     = '0;
                            n_res_count = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PROBE: begin
                if (r_lo < r_hi) begin
                    mem_rd_en = 1'b1;
                    n_state   = ST_CMP;
                end else if (r_action == ssrc_pkg::ACT_INSERT) begin
                    n_pos   = r_lo[AW-1:0];
                    n_idx   = r_count[AW-1:0];
                    n_state = ST_SHIFT;
                end else if (!r_phase) begin
                    // upper bound found, now the lower bound of the low end
                    n_ub     = r_lo;
                    n_phase  = 1'b1;
                    n_key    = r_low;
                    n_strict = 1'b0;
                    n_lo     = '0;
                    n_hi     = r_count;
                end else begin
                    n_res_count = r_ub - r_lo;
                    n_state     = ST_DONE;
                end
            end
            ST_CMP: begin
                if (go_right) begin
                    n_lo = mid + CW'(1);
                end else begin
                    n_hi = mid;
                end
                n_state = ST_PROBE;
            end
            ST_SHIFT: begin
                if (r_idx != r_pos) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = r_idx - AW'(1);
                    n_state     = ST_MOVE;
                end else begin
                    mem_wr_en   = 1'b1;
                    n_count     = r_count + CW'(1);
                    n_res_count = r_count + CW'(1);
                    n_state     = ST_DONE;
                end
            end
            ST_MOVE: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_idx;
                mem_wr_data = mem_rd_data;
                n_idx       = r_idx - AW'(1);
                n_state     = ST_SHIFT;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_count  = res_ext[ssrc_pkg::COUNT_W-1:0];
                    n_out_status = r_res_status;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_ub         <= n_ub;
        r_key        <= n_key;
        r_low        <= n_low;
        r_action     <= n_action;
        r_strict     <= n_strict;
        r_phase      <= n_phase;
        r_pos        <= n_pos;
        r_idx        <= n_idx;
        r_res_count  <= n_res_count;
        r_res_status <= n_res_status;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

    `SSRC_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(STORE_DEPTH), "stored count beyond depth")
    `SSRC_ASSERT_NOW(a_probe_window, i_clk, i_rst_n, r_state == ST_CMP, (r_lo < r_hi) && (r_hi <= r_count), "probe outside search window")
    `SSRC_ASSERT_NOW(a_shift_order, i_clk, i_rst_n, r_state == ST_SHIFT || r_state == ST_MOVE, r_idx >= r_pos, "shift index below insert position")
    `SSRC_ASSERT_NEXT(a_full_drop, i_clk, i_rst_n, i_req.valid && i_req.ready && i_req.action == ssrc_pkg::ACT_INSERT && r_count == CW'(STORE_DEPTH), r_state == ST_DONE && r_res_status && r_count == CW'(STORE_DEPTH), "full insert not dropped")
    `SSRC_ASSERT_NOW(a_query_bound, i_clk, i_rst_n, r_state == ST_DONE && r_action == ssrc_pkg::ACT_QUERY, r_res_count <= r_count, "range count above stored count")

endmodule

FILE: rtl/core/ssrc_store.sv
module ssrc_store #(
    parameter int DEPTH = ssrc_pkg::STORE_DEPTH_D
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]  i_wr_addr,
    input  ssrc_pkg::t_value          i_wr_data,
    input  logic                      i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]  i_rd_addr,
    output ssrc_pkg::t_value          o_rd_data
);

    ssrc_pkg::t_value r_mem [DEPTH];
    ssrc_pkg::t_value r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
